/* rtl/core/vft_pkg.sv */
// ----------------------------------------------------------------------------
// vft_pkg: shared types and constants of the virtual flywheel torque unit
// Q16.16 helpers, controller/datapath command bundle, divider sizing.
// ----------------------------------------------------------------------------
package vft_pkg;

  localparam int unsigned CFG_W     = 31;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned GAP_W     = 17;

  localparam logic [31:0]      GAP_MAX_US     = 32'd100000;
  localparam logic [GAP_W-1:0] GAP_DEFAULT_US = 17'd1000;

  // Divide by one million through a reciprocal multiply.
  // |a*g| <= 2^31 * 100000 < 2^48, so the quotient fits in 28 bits.
  // floor(mag / 2^16) * RECIP_US / 2^35 undershoots by less than one, so the
  // estimate is off by at most one and the remainder stays below two million.
  localparam int unsigned MAG_W    = 48;
  localparam int unsigned QUO_W    = 28;
  localparam int unsigned REM_W    = 21;
  localparam int unsigned RECIP_SH = 35;
  localparam logic [REM_W-1:0] US_PER_S = 21'd1000000;
  localparam logic [31:0]      RECIP_US = 32'd2251799813;  // floor(2^51 / 10^6)

  localparam logic [31:0]        INV_INERTIA_RST = 32'd65536;
  localparam logic signed [63:0] SAT_MAX         = 64'sd2147483647;
  localparam logic signed [63:0] SAT_MIN         = -64'sd2147483648;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_COUPLING    = 2'd0,
    REG_DAMPING     = 2'd1,
    REG_INV_INERTIA = 2'd2,
    REG_FRICTION    = 2'd3
  } cfg_reg_e;

  typedef enum logic [2:0] {
    MUL_KE = 3'd0,  // coupling gain * angle error
    MUL_DV = 3'd1,  // damping * velocity
    MUL_FR = 3'd2,  // force * inverse inertia
    MUL_AG = 3'd3,  // accel * gap
    MUL_VG = 3'd4   // new velocity * gap
  } mul_sel_e;

  typedef struct packed {
    logic     load_sample;
    logic     load_reset;
    logic     mul_en;
    mul_sel_e mul_sel;
    logic     save_kerr;
    logic     save_force;
    logic     save_accel;
    logic     div_start;
    logic     upd_vel;
    logic     upd_pos;
    logic     load_out;
  } dp_cmd_t;

  typedef struct packed {
    logic div_done;
  } dp_stat_t;

  function automatic logic signed [31:0] sat32(input logic signed [63:0] x);
    if (x > SAT_MAX) begin
      return 32'sh7fffffff;
    end else if (x < SAT_MIN) begin
      return 32'sh80000000;
    end
    return x[31:0];
  endfunction

endpackage

/* rtl/core/vft_div.sv */
// ----------------------------------------------------------------------------
// vft_div: staged signed divide by one million
// Reciprocal multiply, remainder check and one-step fix; truncates to zero.
// ----------------------------------------------------------------------------
module vft_div (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             start_i,
  input  logic                             neg_i,
  input  logic [vft_pkg::MAG_W-1:0]        mag_i,
  output logic                             done_o,
  output logic signed [vft_pkg::QUO_W:0]   quo_o
);
  import vft_pkg::*;

  logic             v1_q, v2_q, v3_q, done_q;
  logic [MAG_W-1:0] mag_q;
  logic             neg_q;
  logic [63:0]      prod_q, prod_d;
  logic [QUO_W-1:0] est_q, est_d;
  logic [REM_W-1:0] rem_q, rem_d;
  logic [QUO_W-1:0] quo_q, quo_d;

  always_comb begin
    prod_d = {32'd0, mag_q[MAG_W-1:16]} * {32'd0, RECIP_US};
    est_d  = prod_q[RECIP_SH+QUO_W-1:RECIP_SH];
    // remainder is below two divisors, so its low bits are exact
    rem_d  = mag_q[REM_W-1:0] - est_d[REM_W-1:0] * US_PER_S;
    quo_d  = est_q + QUO_W'(rem_q >= US_PER_S);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q   <= 1'b0;
      v2_q   <= 1'b0;
      v3_q   <= 1'b0;
      done_q <= 1'b0;
    end else begin
      v1_q   <= start_i;
      v2_q   <= v1_q;
      v3_q   <= v2_q;
      done_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      mag_q <= mag_i;
      neg_q <= neg_i;
    end
    if (v1_q) begin
      prod_q <= prod_d;
    end
    if (v2_q) begin
      est_q <= est_d;
      rem_q <= rem_d;
    end
    if (v3_q) begin
      quo_q <= quo_d;
    end
  end

  assign done_o = done_q;
  assign quo_o  = neg_q ? -$signed({1'b0, quo_q}) : $signed({1'b0, quo_q});

endmodule

/* rtl/core/vft_dp.sv */
// ----------------------------------------------------------------------------
// vft_dp: flywheel datapath
// Config registers, flywheel state, one shared 32x32 multiplier, divider.
// ----------------------------------------------------------------------------
module vft_dp (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [vft_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [vft_pkg::CFG_W-1:0]      cfg_data_i,
  input  logic signed [31:0]             knob_angle_i,
  input  logic [31:0]                    timestamp_us_i,
  input  vft_pkg::dp_cmd_t               cmd_i,
  output vft_pkg::dp_stat_t              stat_o,
  output logic signed [31:0]             torque_o
);
  import vft_pkg::*;

  logic [CFG_W-1:0] k_q, d_q, r_q, f_q;

  logic signed [31:0] pos_q, vel_q;
  logic [31:0]        ts_q;

  logic [GAP_W-1:0]   gap_q, gap_d;
  logic signed [31:0] e_q, e_d;
  logic signed [63:0] prod_q, prod_d;
  logic signed [47:0] kf_q;
  logic signed [31:0] torque_q, torque_d;
  logic signed [31:0] force_q, force_d;
  logic signed [31:0] accel_q, accel_d;
  logic signed [31:0] out_q;

  logic signed [31:0] op_a, op_b;
  logic signed [63:0] prod_sh, prod_neg;
  logic [31:0]        ts_diff;
  logic signed [31:0] accel_raw;
  logic signed [63:0] accel_x, fric_x;
  logic [63:0]        mag;
  logic               div_done;
  logic signed [QUO_W:0] quo;
  logic signed [63:0] quo_x;

  // -------- config --------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      k_q <= '0;
      d_q <= '0;
      r_q <= INV_INERTIA_RST[CFG_W-1:0];
      f_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        REG_COUPLING:    k_q <= cfg_data_i;
        REG_DAMPING:     d_q <= cfg_data_i;
        REG_INV_INERTIA: r_q <= cfg_data_i;
        REG_FRICTION:    f_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // -------- sample front end --------
  always_comb begin
    ts_diff = timestamp_us_i - ts_q;
    if (ts_diff == '0 || ts_diff > GAP_MAX_US) begin
      gap_d = GAP_DEFAULT_US;
    end else begin
      gap_d = ts_diff[GAP_W-1:0];
    end
    e_d = sat32($signed({{32{knob_angle_i[31]}}, knob_angle_i})
              - $signed({{32{pos_q[31]}}, pos_q}));
  end

  // -------- shared multiplier --------
  always_comb begin
    case (cmd_i.mul_sel)
      MUL_KE:  begin op_a = $signed({1'b0, k_q}); op_b = e_q;   end
      MUL_DV:  begin op_a = $signed({1'b0, d_q}); op_b = vel_q; end
      MUL_FR:  begin op_a = $signed({1'b0, r_q}); op_b = force_q; end
      MUL_AG:  begin op_a = accel_q; op_b = $signed({15'd0, gap_q}); end
      MUL_VG:  begin op_a = vel_q;   op_b = $signed({15'd0, gap_q}); end
      default: begin op_a = '0;      op_b = '0; end
    endcase
    prod_d = op_a * op_b;
  end

  // -------- post-multiply arithmetic --------
  always_comb begin
    prod_sh  = prod_q >>> 16;            // floor(x / 2^16)
    prod_neg = -prod_q;
    torque_d = sat32(prod_neg >>> 16);
    force_d  = sat32($signed({{16{kf_q[47]}}, kf_q}) - prod_sh);

    accel_raw = sat32(prod_sh);
    accel_x   = $signed({{32{accel_raw[31]}}, accel_raw});
    fric_x    = $signed({33'd0, f_q});
    if (f_q != '0 && !vel_q[31] && vel_q != '0) begin
      accel_d = sat32(accel_x - fric_x);
    end else if (f_q != '0 && vel_q[31]) begin
      accel_d = sat32(accel_x + fric_x);
    end else begin
      accel_d = accel_raw;
    end

    mag   = prod_q[63] ? prod_neg : prod_q;
    quo_x = $signed({{(63 - QUO_W){quo[QUO_W]}}, quo});
  end

  vft_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.div_start),
    .neg_i   (prod_q[63]),
    .mag_i   (mag[MAG_W-1:0]),
    .done_o  (div_done),
    .quo_o   (quo)
  );

  assign stat_o.div_done = div_done;

  // -------- flywheel state --------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
      vel_q <= '0;
      ts_q  <= '0;
    end else begin
      if (cmd_i.load_reset) begin
        pos_q <= knob_angle_i;
        vel_q <= '0;
        ts_q  <= timestamp_us_i;
      end
      if (cmd_i.load_sample) begin
        ts_q <= timestamp_us_i;
      end
      if (cmd_i.upd_vel) begin
        vel_q <= sat32($signed({{32{vel_q[31]}}, vel_q}) + quo_x);
      end
      if (cmd_i.upd_pos) begin
        pos_q <= sat32($signed({{32{pos_q[31]}}, pos_q}) + quo_x);
      end
    end
  end

  // -------- working registers --------
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_sample) begin
      gap_q <= gap_d;
      e_q   <= e_d;
    end
    if (cmd_i.mul_en) begin
      prod_q <= prod_d;
    end
    if (cmd_i.save_kerr) begin
      kf_q     <= prod_sh[47:0];
      torque_q <= torque_d;
    end
    if (cmd_i.save_force) begin
      force_q <= force_d;
    end
    if (cmd_i.save_accel) begin
      accel_q <= accel_d;
    end
    if (cmd_i.load_out) begin
      out_q <= torque_q;
    end
  end

  assign torque_o = out_q;

endmodule

/* rtl/core/vft_ctrl.sv */
// ----------------------------------------------------------------------------
// vft_ctrl: sequencing of one torque sample
// Walks the shared multiplier and divider through the update, owns handshakes.
// ----------------------------------------------------------------------------
module vft_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               func_i,
  input  logic               out_stall_i,
  input  vft_pkg::dp_stat_t  stat_i,
  output logic               in_stall_o,
  output logic               out_valid_o,
  output vft_pkg::dp_cmd_t   cmd_o
);
  import vft_pkg::*;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_MKE  = 4'd1;
  localparam logic [3:0] S_MDV  = 4'd2;
  localparam logic [3:0] S_FRC  = 4'd3;
  localparam logic [3:0] S_MFR  = 4'd4;
  localparam logic [3:0] S_ACC  = 4'd5;
  localparam logic [3:0] S_MAG  = 4'd6;
  localparam logic [3:0] S_DSA  = 4'd7;
  localparam logic [3:0] S_DWA  = 4'd8;
  localparam logic [3:0] S_VEL  = 4'd9;
  localparam logic [3:0] S_MVG  = 4'd10;
  localparam logic [3:0] S_DSB  = 4'd11;
  localparam logic [3:0] S_DWB  = 4'd12;
  localparam logic [3:0] S_POS  = 4'd13;
  localparam logic [3:0] S_OUT  = 4'd14;

  logic [3:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;
  logic       in_beat, out_free;
  dp_cmd_t    cmd;

  assign in_beat  = in_valid_i && (state_q == S_IDLE);
  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    cmd         = '0;
    cmd.mul_sel = MUL_KE;
    state_d     = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_beat) begin
          if (func_i) begin
            cmd.load_reset = 1'b1;
          end else begin
            cmd.load_sample = 1'b1;
            state_d         = S_MKE;
          end
        end
      end
      S_MKE: begin
        cmd.mul_en = 1'b1;
        state_d    = S_MDV;
      end
      S_MDV: begin
        cmd.mul_en    = 1'b1;
        cmd.mul_sel   = MUL_DV;
        cmd.save_kerr = 1'b1;
        state_d       = S_FRC;
      end
      S_FRC: begin
        cmd.save_force = 1'b1;
        state_d        = S_MFR;
      end
      S_MFR: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_FR;
        state_d     = S_ACC;
      end
      S_ACC: begin
        cmd.save_accel = 1'b1;
        state_d        = S_MAG;
      end
      S_MAG: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_AG;
        state_d     = S_DSA;
      end
      S_DSA: begin
        cmd.div_start = 1'b1;
        state_d       = S_DWA;
      end
      S_DWA: begin
        if (stat_i.div_done) begin
          state_d = S_VEL;
        end
      end
      S_VEL: begin
        cmd.upd_vel = 1'b1;
        state_d     = S_MVG;
      end
      S_MVG: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_VG;
        state_d     = S_DSB;
      end
      S_DSB: begin
        cmd.div_start = 1'b1;
        state_d       = S_DWB;
      end
      S_DWB: begin
        if (stat_i.div_done) begin
          state_d = S_POS;
        end
      end
      S_POS: begin
        cmd.upd_pos = 1'b1;
        state_d     = S_OUT;
      end
      S_OUT: begin
        if (out_free) begin
          cmd.load_out = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase

    if (cmd.load_out) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign cmd_o       = cmd;
  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

/* rtl/core/virtual_flywheel_torque_unit.sv */
// ----------------------------------------------------------------------------
// virtual_flywheel_torque_unit: spring-coupled virtual flywheel torque
// A torque-sample beat yields one result beat; a flywheel reset beat yields no
//   result. A sample runs through five passes of the shared multiplier and two
//   reciprocal divides by one million, and no new beat is taken until it has
//   reached the output register; that register lets a new sample start while a
//   result waits. Async active-low reset clears state and config to defaults at
//   once; no clearing pass.
// ----------------------------------------------------------------------------
module virtual_flywheel_torque_unit (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [vft_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [vft_pkg::CFG_W-1:0]      cfg_data_i,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic                           func_i,
  input  logic signed [31:0]             knob_angle_i,
  input  logic [31:0]                    timestamp_us_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic signed [31:0]             torque_o
);
  import vft_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  vft_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .func_i      (func_i),
    .out_stall_i (out_stall_i),
    .stat_i      (stat),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .cmd_o       (cmd)
  );

  vft_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i),
    .knob_angle_i   (knob_angle_i),
    .timestamp_us_i (timestamp_us_i),
    .cmd_i          (cmd),
    .stat_o         (stat),
    .torque_o       (torque_o)
  );

endmodule

/* tb/sv/virtual_flywheel_torque_unit_tb.sv */
// ----------------------------------------------------------------------------
// virtual_flywheel_torque_unit_tb: self-checking bench for the flywheel unit
// A flywheel model tracks position, velocity and last timestamp and predicts
// each torque beat. Directed beats hit gap, wrap and saturation corners over
// extreme register settings. Random phases follow with bursty input traffic,
// a patterned output stall and one long output hold-off.
// ----------------------------------------------------------------------------
module virtual_flywheel_torque_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import vft_pkg::*;

  localparam int          LIMIT         = 1_000_000;
  localparam int          SETTLE_CYCLES = 64;
  localparam int          HOLD_CYCLES   = 600;
  localparam int          HOLD_AFTER    = 400;
  localparam int          MAX_REPORTS   = 10;
  localparam int          RAND_PHASES   = 8;
  localparam int          PHASE_BEATS   = 215;
  localparam longint      MICROS        = 1000000;
  localparam logic [30:0] REG_MAX       = 31'h7fffffff;
  localparam logic [30:0] Q16_ONE       = 31'd65536;
  localparam logic signed [31:0] ANGLE_MAX = 32'sh7fffffff;
  localparam logic signed [31:0] ANGLE_MIN = 32'sh80000000;
  localparam bit FUNC_SAMPLE = 1'b0;
  localparam bit FUNC_RESYNC = 1'b1;

  typedef struct {
    bit                 func;
    logic signed [31:0] angle;
    logic [31:0]        ts;
  } beat_t;

  class flywheel_torque_model;
    logic [30:0]        gain, damping, inv_inertia, friction;
    logic signed [31:0] position, velocity;
    logic [31:0]        last_ts;
    logic signed [31:0] torque_due_q[$];
    int errors, reported, checked, samples, resyncs, saturated;

    function new();
      gain = '0;
      damping = '0;
      inv_inertia = Q16_ONE;
      friction = '0;
      position = '0;
      velocity = '0;
      last_ts = '0;
    endfunction

    function logic signed [31:0] clamp32(longint x);
      if (x > longint'(ANGLE_MAX)) return ANGLE_MAX;
      if (x < longint'(ANGLE_MIN)) return ANGLE_MIN;
      return x[31:0];
    endfunction

    function void set_reg(cfg_reg_e idx, logic [30:0] v);
      case (idx)
        REG_COUPLING:    gain = v;
        REG_DAMPING:     damping = v;
        REG_INV_INERTIA: inv_inertia = v;
        REG_FRICTION:    friction = v;
        default: ;
      endcase
    endfunction

    function void note_input(beat_t b);
      logic [31:0]        gap;
      longint             err, kerr, net_f, accel;
      logic signed [31:0] want;
      if (b.func == FUNC_RESYNC) begin
        position = b.angle;
        velocity = '0;
        last_ts = b.ts;
        resyncs++;
        return;
      end
      gap = b.ts - last_ts;
      last_ts = b.ts;
      if (gap == 0 || gap > GAP_MAX_US) gap = 32'(GAP_DEFAULT_US);
      err = clamp32(longint'(b.angle) - longint'(position));
      kerr = longint'(gain) * err;
      net_f = clamp32((kerr >>> 16) - ((longint'(damping) * longint'(velocity)) >>> 16));
      accel = clamp32((net_f * longint'(inv_inertia)) >>> 16);
      if (friction != 0) begin
        if (velocity > 0) accel = clamp32(accel - longint'(friction));
        else if (velocity < 0) accel = clamp32(accel + longint'(friction));
      end
      // velocity first, position then moves with the new velocity
      velocity = clamp32(longint'(velocity) + (accel * longint'(gap)) / MICROS);
      position = clamp32(longint'(position) + (longint'(velocity) * longint'(gap)) / MICROS);
      want = clamp32((-kerr) >>> 16);
      if (want == ANGLE_MAX || want == ANGLE_MIN) saturated++;
      torque_due_q.push_back(want);
      samples++;
    endfunction

    function void check_torque(logic signed [31:0] got);
      logic signed [31:0] want;
      if (torque_due_q.size() == 0) begin
        errors++;
        if (reported < MAX_REPORTS) begin
          $display("unexpected torque beat: got %0d", got);
          reported++;
        end
        return;
      end
      want = torque_due_q.pop_front();
      checked++;
      if (got !== want) begin
        errors++;
        if (reported < MAX_REPORTS) begin
          $display("torque mismatch on result %0d: expected %0d, got %0d", checked, want, got);
          reported++;
        end
      end
    endfunction

    function int pending();
      return torque_due_q.size();
    endfunction
  endclass

  logic               clk;
  logic               rst_n;
  logic               cfg_we;
  cfg_reg_e           cfg_idx;
  logic [CFG_W-1:0]   cfg_data;
  logic               in_valid;
  logic               in_stall;
  logic               func;
  logic signed [31:0] knob_angle;
  logic [31:0]        timestamp_us;
  logic               out_valid;
  logic               out_stall;
  logic signed [31:0] torque;

  flywheel_torque_model flywheel = new();
  beat_t              stim_q[$];
  int                 accepted_beats;
  int                 cycles;
  int                 settings;
  logic [31:0]        gen_ts;
  logic signed [31:0] gen_angle;

  virtual_flywheel_torque_unit uut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .cfg_we_i       (cfg_we),
    .cfg_idx_i      (cfg_idx),
    .cfg_data_i     (cfg_data),
    .in_valid_i     (in_valid),
    .in_stall_o     (in_stall),
    .func_i         (func),
    .knob_angle_i   (knob_angle),
    .timestamp_us_i (timestamp_us),
    .out_valid_o    (out_valid),
    .out_stall_i    (out_stall),
    .torque_o       (torque)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == LIMIT) begin
      $display("virtual_flywheel_torque_unit_tb: done, errors");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) flywheel.check_torque(torque);
  end

  // receiver: segments of free flow, light and heavy stalling, one long hold
  initial begin : receiver
    int  seg_len;
    int  mode;
    bit  held;
    held = 1'b0;
    out_stall = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      if (!held && accepted_beats >= HOLD_AFTER) begin
        held = 1'b1;
        @(posedge clk);
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      seg_len = $urandom_range(10, 300);
      mode = $urandom_range(0, 99);
      repeat (seg_len) begin
        @(posedge clk);
        if (mode < 30) out_stall <= 1'b0;
        else if (mode < 75) out_stall <= ($urandom_range(0, 99) < 30);
        else out_stall <= ($urandom_range(0, 99) < 80);
      end
    end
  end

  task automatic push_beat(bit f, logic signed [31:0] a, logic [31:0] t);
    beat_t b;
    b.func = f;
    b.angle = a;
    b.ts = t;
    stim_q.push_back(b);
  endtask

  task automatic write_reg(cfg_reg_e idx, logic [30:0] v);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_data <= v;
    flywheel.set_reg(idx, v);
  endtask

  task automatic program_regs(logic [30:0] k, logic [30:0] d, logic [30:0] r, logic [30:0] f);
    write_reg(REG_COUPLING, k);
    write_reg(REG_DAMPING, d);
    write_reg(REG_INV_INERTIA, r);
    write_reg(REG_FRICTION, f);
    @(posedge clk);
    cfg_we <= 1'b0;
    settings++;
  endtask

  // send everything queued, in bursts with random gaps between them
  task automatic drive_beats();
    int    burst;
    int    gap_len;
    int    sel;
    bit    done;
    beat_t cur;
    if (stim_q.size() == 0) return;
    burst = $urandom_range(1, 32);
    cur = stim_q.pop_front();
    @(posedge clk);
    in_valid <= 1'b1;
    func <= cur.func;
    knob_angle <= cur.angle;
    timestamp_us <= cur.ts;
    done = 1'b0;
    while (!done) begin
      @(posedge clk);
      if (in_valid && !in_stall) begin
        flywheel.note_input(cur);
        accepted_beats++;
        if (stim_q.size() == 0) begin
          in_valid <= 1'b0;
          done = 1'b1;
        end else begin
          burst--;
          if (burst == 0) begin
            burst = $urandom_range(1, 32);
            sel = $urandom_range(0, 99);
            gap_len = (sel < 25) ? 0 : (sel < 75) ? $urandom_range(1, 6) : $urandom_range(7, 50);
            if (gap_len > 0) begin
              in_valid <= 1'b0;
              repeat (gap_len) @(posedge clk);
            end
          end
          cur = stim_q.pop_front();
          in_valid <= 1'b1;
          func <= cur.func;
          knob_angle <= cur.angle;
          timestamp_us <= cur.ts;
        end
      end
    end
  endtask

  // wait out all expected torque plus any resync still in flight
  task automatic settle();
    while (flywheel.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic logic [30:0] pick_extreme();
    case ($urandom_range(0, 3))
      0:       return '0;
      1:       return REG_MAX;
      2:       return 31'd1;
      default: return 31'($urandom);
    endcase
  endfunction

  task automatic queue_random_beats(int n);
    int          sel;
    logic [31:0] g;
    bit          f;
    repeat (n) begin
      sel = $urandom_range(0, 99);
      if (sel < 65) g = $urandom_range(1, 2000);
      else if (sel < 75) g = '0;
      else if (sel < 80) g = $urandom_range(99998, 100002);
      else if (sel < 88) g = $urandom_range(2000, 100000);
      else if (sel < 94) g = $urandom_range(32'hffffffff, 100001);
      else g = $urandom;
      gen_ts = gen_ts + g;
      sel = $urandom_range(0, 99);
      if (sel < 80) gen_angle = gen_angle + 32'(int'($urandom_range(0, 262144)) - 131072);
      else if (sel < 90) gen_angle = $urandom;
      else gen_angle = $urandom_range(0, 1) ? ANGLE_MAX : ANGLE_MIN;
      f = ($urandom_range(0, 99) < 8) ? FUNC_RESYNC : FUNC_SAMPLE;
      push_beat(f, gen_angle, gen_ts);
    end
  endtask

  initial begin : main
    int kind;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_idx = REG_COUPLING;
    cfg_data = '0;
    in_valid = 1'b0;
    func = FUNC_SAMPLE;
    knob_angle = '0;
    timestamp_us = '0;
    accepted_beats = 0;
    cycles = 0;
    settings = 0;
    gen_ts = '0;
    gen_angle = '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // first sample measures its gap from zero; then zero gap, over-range gap,
    // the 100000 us boundary, timestamp wrap and saturating angle errors
    program_regs(31'd4 << 16, 31'd1 << 15, 31'd2 << 16, 31'd1 << 12);
    push_beat(FUNC_SAMPLE, 32'sd65536, 32'd500);
    push_beat(FUNC_SAMPLE, 32'sd131072, 32'd500);
    push_beat(FUNC_SAMPLE, 32'sd131072, 32'd100501);
    push_beat(FUNC_SAMPLE, -32'sd65536, 32'd200501);
    push_beat(FUNC_SAMPLE, -32'sd65536, 32'd200502);
    push_beat(FUNC_RESYNC, ANGLE_MAX, 32'hffffff00);
    push_beat(FUNC_SAMPLE, ANGLE_MIN, 32'h00000010);
    push_beat(FUNC_RESYNC, ANGLE_MIN, 32'h00000020);
    push_beat(FUNC_SAMPLE, ANGLE_MAX, 32'h00000420);
    push_beat(FUNC_SAMPLE, ANGLE_MAX, 32'h00000820);
    push_beat(FUNC_SAMPLE, '0, 32'h00001820);
    drive_beats();
    settle();

    // every register at full scale
    program_regs(REG_MAX, REG_MAX, REG_MAX, REG_MAX);
    push_beat(FUNC_SAMPLE, ANGLE_MAX, 32'd101820);
    push_beat(FUNC_SAMPLE, ANGLE_MIN, 32'd201820);
    push_beat(FUNC_SAMPLE, '0, 32'd301820);
    push_beat(FUNC_SAMPLE, ANGLE_MAX, 32'd301821);
    push_beat(FUNC_SAMPLE, ANGLE_MIN, 32'd302821);
    drive_beats();
    settle();

    // zero inverse inertia: only friction moves the flywheel
    program_regs(Q16_ONE, Q16_ONE, '0, Q16_ONE);
    push_beat(FUNC_SAMPLE, 32'sd3 << 16, 32'd303821);
    push_beat(FUNC_SAMPLE, 32'sd3 << 16, 32'd353821);
    push_beat(FUNC_SAMPLE, -32'sd3 << 16, 32'd403821);
    drive_beats();
    settle();

    program_regs('0, '0, '0, '0);
    push_beat(FUNC_SAMPLE, ANGLE_MAX, 32'd404821);
    push_beat(FUNC_SAMPLE, ANGLE_MIN, 32'd405821);
    drive_beats();
    settle();

    gen_ts = 32'd405821;
    for (int p = 0; p < RAND_PHASES; p++) begin
      kind = $urandom_range(0, 3);
      if (kind < 2) begin
        program_regs(31'($urandom_range(0, 20 << 16)), 31'($urandom_range(0, 4 << 16)),
                     31'($urandom_range(1 << 12, 4 << 16)),
                     31'($urandom_range(0, 2 << 16)));
      end else if (kind == 2) begin
        program_regs(31'($urandom), 31'($urandom), 31'($urandom), 31'($urandom));
      end else begin
        program_regs(pick_extreme(), pick_extreme(), pick_extreme(), pick_extreme());
      end
      queue_random_beats(PHASE_BEATS);
      drive_beats();
      settle();
    end

    if (flywheel.pending() != 0) flywheel.errors += flywheel.pending();
    $display("covered %0d torque samples and %0d flywheel resyncs over %0d register settings",
             flywheel.samples, flywheel.resyncs, settings);
    $display("%0d torque beats checked, %0d of them at a saturation rail",
             flywheel.checked, flywheel.saturated);
    if (flywheel.errors == 0) begin
      $display("virtual_flywheel_torque_unit_tb: done, clean");
    end else begin
      $display("virtual_flywheel_torque_unit_tb: done, errors");
    end
    $finish;
  end

endmodule

/* virtual_flywheel_torque_unit.f */
rtl/core/vft_pkg.sv
rtl/core/vft_div.sv
rtl/core/vft_dp.sv
rtl/core/vft_ctrl.sv
rtl/core/virtual_flywheel_torque_unit.sv
tb/sv/virtual_flywheel_torque_unit_tb.sv
